// ===== rtl/astcm_pkg.sv =====
// ---------------------------------------------------------------------------
// astcm_pkg
// Shared types and constants for the tile collision box mover.
// ---------------------------------------------------------------------------
package astcm_pkg;

    localparam int MAP_COLS_DEF    = 32;
    localparam int MAP_ROWS_DEF    = 30;
    localparam int BOX_W_TILES_DEF = 2;
    localparam int BOX_H_TILES_DEF = 2;

    localparam logic [7:0] BEH_SOLID = 8'd1;
    localparam logic [7:0] BEH_WALL  = 8'd2;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_PLACE = 2'd1;
    localparam logic [1:0] ACT_MOVE  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    typedef struct packed {
        logic [7:0] pos;
        logic [7:0] frac;
    } axis_t;

    function automatic int axis_limit(input int tiles, input int box_tiles);
        int lim;
        lim = tiles * 8 - box_tiles * 8;
        if (lim < 0) begin
            lim = 0;
        end
        if (lim > 255) begin
            lim = 255;
        end
        return lim;
    endfunction

endpackage

// ===== rtl/axis_separated_tile_collision_move.sv =====
// Move step: X then Y, each an add state and then a probe state that makes five
//   map reads on one read port; other actions go from execute straight to done.
//   One item at a time: no new item is taken until the result is registered,
//   and the done state waits while an earlier result waits for m_ready.
// Reset: synchronous active-low; clears position and fractions, then sweeps all
//   MAP_COLS*MAP_ROWS map cells (960 by default) to zero, not ready meanwhile.
// ---------------------------------------------------------------------------
// axis_separated_tile_collision_move
// Tile map box mover with axis-separated collision in 8.8 fixed point.
// ---------------------------------------------------------------------------
module axis_separated_tile_collision_move #(
    parameter int MAP_COLS    = astcm_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS    = astcm_pkg::MAP_ROWS_DEF,
    parameter int BOX_W_TILES = astcm_pkg::BOX_W_TILES_DEF,
    parameter int BOX_H_TILES = astcm_pkg::BOX_H_TILES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic [9:0]         s_cell_index,
    input  logic [7:0]         s_cell_behaviour,
    input  logic [7:0]         s_place_x,
    input  logic [7:0]         s_place_y,
    input  logic signed [15:0] s_vel_x,
    input  logic signed [15:0] s_vel_y,
    input  logic signed [15:0] s_speed_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_pos_x,
    output logic [7:0]         m_pos_y,
    output logic [7:0]         m_frac_x,
    output logic [7:0]         m_frac_y,
    output logic               m_blocked_x,
    output logic               m_blocked_y,
    output logic signed [15:0] m_speed_out
);

    localparam int DEPTH = MAP_COLS * MAP_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [7:0] XLIM = 8'(astcm_pkg::axis_limit(MAP_COLS, BOX_W_TILES));
    localparam logic [7:0] YLIM = 8'(astcm_pkg::axis_limit(MAP_ROWS, BOX_H_TILES));

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_PROBE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [2:0] PROBE_LAST = 3'd5;

    logic [2:0]         state_reg,  state_next;
    logic [AW-1:0]      clr_reg,    clr_next;
    logic [2:0]         cnt_reg,    cnt_next;
    logic               axis_reg,   axis_next;
    logic               hit_reg,    hit_next;
    logic               on_map_reg;
    astcm_pkg::axis_t   x_reg,      x_next;
    astcm_pkg::axis_t   y_reg,      y_next;
    astcm_pkg::axis_t   trial_reg,  trial_next;
    logic               bx_reg,     bx_next;
    logic               by_reg,     by_next;
    logic               m_valid_reg, m_valid_next;

    logic [1:0]         act_reg;
    logic [9:0]         idx_reg;
    logic [7:0]         beh_reg;
    logic [7:0]         plx_reg;
    logic [7:0]         ply_reg;
    logic signed [15:0] vx_reg;
    logic signed [15:0] vy_reg;
    logic signed [15:0] speed_reg;

    logic [7:0]         opx_reg, opy_reg, ofx_reg, ofy_reg;
    logic               obx_reg, oby_reg;
    logic signed [15:0] ospd_reg;

    astcm_pkg::axis_t   int_cur;
    astcm_pkg::axis_t   int_nxt;
    logic signed [15:0] int_vel;
    logic [7:0]         int_lim;

    logic [7:0]         probe_bx;
    logic [7:0]         probe_by;
    logic [AW-1:0]      probe_addr;
    logic               probe_on_map;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [7:0]         ram_wdata;
    logic [7:0]         ram_rdata;

    logic               blk_now;
    logic               hit_final;
    logic [16:0]        abs_x;
    logic [16:0]        abs_y;
    logic               halve;
    logic               s_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_pos_x     = opx_reg;
    assign m_pos_y     = opy_reg;
    assign m_frac_x    = ofx_reg;
    assign m_frac_y    = ofy_reg;
    assign m_blocked_x = obx_reg;
    assign m_blocked_y = oby_reg;
    assign m_speed_out = ospd_reg;

    assign int_cur = axis_reg ? y_reg : x_reg;
    assign int_vel = axis_reg ? vy_reg : vx_reg;
    assign int_lim = axis_reg ? YLIM : XLIM;

    assign probe_bx = axis_reg ? x_reg.pos : trial_reg.pos;
    assign probe_by = axis_reg ? trial_reg.pos : y_reg.pos;

    astcm_integrate u_integrate (
        .cur (int_cur),
        .vel (int_vel),
        .lim (int_lim),
        .nxt (int_nxt)
    );

    astcm_probe #(
        .MAP_COLS    (MAP_COLS),
        .MAP_ROWS    (MAP_ROWS),
        .BOX_W_TILES (BOX_W_TILES),
        .BOX_H_TILES (BOX_H_TILES)
    ) u_probe (
        .bx     (probe_bx),
        .by     (probe_by),
        .sel    (cnt_reg),
        .addr   (probe_addr),
        .on_map (probe_on_map)
    );

    astcm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (probe_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = 8'd0;
        if (state_reg == ST_CLEAR) begin
            ram_we = 1'b1;
        end else if (state_reg == ST_EXEC && act_reg == astcm_pkg::ACT_WRITE) begin
            ram_we    = ({3'b000, idx_reg} < 13'(DEPTH));
            ram_waddr = AW'(idx_reg);
            ram_wdata = beh_reg;
        end
    end

    always_comb begin
        blk_now   = (cnt_reg != 3'd0) && on_map_reg &&
                    ((ram_rdata == astcm_pkg::BEH_SOLID) || (ram_rdata == astcm_pkg::BEH_WALL));
        hit_final = hit_reg || blk_now;
        abs_x = vx_reg[15] ? 17'(-$signed({vx_reg[15], vx_reg})) : {1'b0, vx_reg};
        abs_y = vy_reg[15] ? 17'(-$signed({vy_reg[15], vy_reg})) : {1'b0, vy_reg};
        halve = (bx_reg && (abs_x >= abs_y)) || (by_reg && (abs_y >= abs_x));
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cnt_next     = cnt_reg;
        axis_next    = axis_reg;
        hit_next     = hit_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        trial_next   = trial_reg;
        bx_next      = bx_reg;
        by_next      = by_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                bx_next    = 1'b0;
                by_next    = 1'b0;
                axis_next  = 1'b0;
                state_next = ST_DONE;
                unique case (act_reg)
                    astcm_pkg::ACT_PLACE: begin
                        x_next.pos  = (plx_reg > XLIM) ? XLIM : plx_reg;
                        y_next.pos  = (ply_reg > YLIM) ? YLIM : ply_reg;
                        x_next.frac = 8'd0;
                        y_next.frac = 8'd0;
                    end
                    astcm_pkg::ACT_MOVE: begin
                        state_next = ST_ADD;
                    end
                    astcm_pkg::ACT_WRITE, astcm_pkg::ACT_NONE: begin
                    end
                endcase
            end
            ST_ADD: begin
                trial_next = int_nxt;
                cnt_next   = 3'd0;
                hit_next   = 1'b0;
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                cnt_next = cnt_reg + 3'd1;
                hit_next = hit_final;
                if (cnt_reg == PROBE_LAST) begin
                    if (!axis_reg) begin
                        bx_next   = hit_final;
                        axis_next = 1'b1;
                        if (!hit_final) begin
                            x_next = trial_reg;
                        end
                        state_next = ST_ADD;
                    end else begin
                        by_next = hit_final;
                        if (!hit_final) begin
                            y_next = trial_reg;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            cnt_reg     <= 3'd0;
            axis_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            x_reg       <= '0;
            y_reg       <= '0;
            bx_reg      <= 1'b0;
            by_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cnt_reg     <= cnt_next;
            axis_reg    <= axis_next;
            hit_reg     <= hit_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            bx_reg      <= bx_next;
            by_reg      <= by_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        trial_reg  <= trial_next;
        on_map_reg <= probe_on_map;
        if (s_fire) begin
            act_reg   <= s_action;
            idx_reg   <= s_cell_index;
            beh_reg   <= s_cell_behaviour;
            plx_reg   <= s_place_x;
            ply_reg   <= s_place_y;
            vx_reg    <= s_vel_x;
            vy_reg    <= s_vel_y;
            speed_reg <= s_speed_in;
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            opx_reg  <= x_reg.pos;
            opy_reg  <= y_reg.pos;
            ofx_reg  <= x_reg.frac;
            ofy_reg  <= y_reg.frac;
            obx_reg  <= bx_reg;
            oby_reg  <= by_reg;
            ospd_reg <= halve ? (speed_reg >>> 1) : speed_reg;
        end
    end

`ifndef SYNTHESIS
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pos_x <= XLIM) && (m_pos_y <= YLIM))
        else $error("result position beyond limit");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready after input transfer");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (state_reg == ST_CLEAR) && !m_valid)
        else $error("reset did not start map clear");

    a_blocked_only_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && (bx_reg || by_reg) |-> (act_reg == astcm_pkg::ACT_MOVE))
        else $error("blocked flag on non-move item");
`endif

endmodule

// ===== rtl/astcm_ram.sv =====
// ---------------------------------------------------------------------------
// astcm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module astcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 960,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/astcm_integrate.sv =====
// ---------------------------------------------------------------------------
// astcm_integrate
// Shared axis unit: add 8.8 velocity to position:fraction, clamp to 0..lim.
// ---------------------------------------------------------------------------
module astcm_integrate (
    input  astcm_pkg::axis_t    cur,
    input  logic signed [15:0]  vel,
    input  logic [7:0]          lim,
    output astcm_pkg::axis_t    nxt
);

    logic signed [16:0] acc;
    logic signed [8:0]  whole;
    logic signed [9:0]  np;
    logic signed [9:0]  lim_ext;

    always_comb begin
        acc     = $signed({9'd0, cur.frac}) + $signed({vel[15], vel});
        whole   = acc[16:8];
        np      = $signed({2'b00, cur.pos}) + $signed({whole[8], whole});
        lim_ext = $signed({2'b00, lim});
        nxt.frac = acc[7:0];
        nxt.pos  = np[7:0];
        if (np[9]) begin
            nxt.pos  = 8'd0;
            nxt.frac = 8'd0;
        end else if (np > lim_ext) begin
            nxt.pos  = lim;
            nxt.frac = 8'd0;
        end
    end

endmodule

// ===== rtl/astcm_probe.sv =====
// ---------------------------------------------------------------------------
// astcm_probe
// Probe point generator: map address and on-map flag for one of five points.
// ---------------------------------------------------------------------------
module astcm_probe #(
    parameter int MAP_COLS    = astcm_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS    = astcm_pkg::MAP_ROWS_DEF,
    parameter int BOX_W_TILES = astcm_pkg::BOX_W_TILES_DEF,
    parameter int BOX_H_TILES = astcm_pkg::BOX_H_TILES_DEF,
    localparam int AW         = $clog2(MAP_COLS * MAP_ROWS)
) (
    input  logic [7:0]    bx,
    input  logic [7:0]    by,
    input  logic [2:0]    sel,
    output logic [AW-1:0] addr,
    output logic          on_map
);

    logic [8:0]  x_far;
    logic [8:0]  x_mid;
    logic [8:0]  y_far;
    logic [8:0]  y_mid;
    logic [5:0]  c0;
    logic [5:0]  c1;
    logic [5:0]  cm;
    logic [5:0]  r0;
    logic [5:0]  r1;
    logic [5:0]  rm;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [12:0] lin;

    always_comb begin
        x_far = {1'b0, bx} + 9'(BOX_W_TILES * 8 - 1);
        x_mid = {1'b0, bx} + 9'(BOX_W_TILES * 4);
        y_far = {1'b0, by} + 9'(BOX_H_TILES * 8 - 1);
        y_mid = {1'b0, by} + 9'(BOX_H_TILES * 4);
        c0 = {1'b0, bx[7:3]};
        c1 = x_far[8:3];
        cm = x_mid[8:3];
        r0 = {1'b0, by[7:3]};
        r1 = y_far[8:3];
        rm = y_mid[8:3];
        unique case (sel)
            3'd0: begin
                col = c0;
                row = r0;
            end
            3'd1: begin
                col = c1;
                row = r0;
            end
            3'd2: begin
                col = c0;
                row = r1;
            end
            3'd3: begin
                col = c1;
                row = r1;
            end
            default: begin
                col = cm;
                row = rm;
            end
        endcase
        on_map = ({1'b0, col} < 7'(MAP_COLS)) && ({1'b0, row} < 7'(MAP_ROWS));
        lin    = 13'(row) * 13'(MAP_COLS) + 13'(col);
        addr   = lin[AW-1:0];
    end

endmodule
